>>> hw/rtl/emr_pkg.sv
// shared types, constants and helpers of the entropy mixer range reducer
package emr_pkg;

  localparam int WORD_W      = 32;
  localparam int CFG_INDEX_W = 2;
  localparam int Q_DEPTH     = 2;
  localparam int DIV_STEPS   = WORD_W;
  localparam int STEP_W      = $clog2(DIV_STEPS);

  localparam logic [CFG_INDEX_W-1:0] CFG_RANGE_ENABLE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_RANGE_LOW    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_RANGE_HIGH   = 2'd2;

  localparam logic [WORD_W-1:0] ACC_RESET  = 32'hDEADBEEF;
  localparam logic [WORD_W-1:0] LCG_MUL    = 32'd1664525;
  localparam logic [WORD_W-1:0] LCG_ADD    = 32'd1013904223;
  localparam logic [WORD_W-1:0] HIGH_RESET = 32'hFFFFFFFF;

  typedef struct packed {
    logic [WORD_W-1:0] sample_a;
    logic [WORD_W-1:0] sample_b;
    logic [WORD_W-1:0] sample_c;
    logic [WORD_W-1:0] sample_d;
    logic [WORD_W-1:0] timer_word;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] random_value;
    logic [WORD_W-1:0] draw_count;
  } out_item_t;

  typedef struct packed {
    logic              range_enable;
    logic [WORD_W-1:0] range_low;
    logic [WORD_W-1:0] range_high;
  } cfg_t;

  typedef enum logic [1:0] {
    KIND_RAW,
    KIND_EMPTY,
    KIND_RANGE
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [WORD_W-1:0] word;
    logic [WORD_W-1:0] count;
  } q_entry_t;

  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x, input int k);
    logic [2*WORD_W-1:0] dbl;
    dbl = {x, x} << k;
    return dbl[2*WORD_W-1:WORD_W];
  endfunction

endpackage

>>> hw/rtl/entropy_mixer_range_reducer.sv
// top level of the entropy mixer range reducer
//
// in_*: one item carries four noise samples and a timer word; accepted when
// in_valid is high and in_stall is low. out_*: one item carries the random
// value and the draw count; taken when out_valid is high and out_stall is low.
// cfg_*: register writes (0 range enable, 1 range low, 2 range high); the user
// must do them only while the block is idle (not enforced); other indexes are ignored.
// the front end mixes and steps the accumulator in the accept cycle (not for
// an empty range) and puts the item in a two-entry queue; the back end drains it.
// raw mode and empty range: queued, then registered; one item per cycle when not stalled.
// range mode: a restoring remainder unit, one bit a cycle, reduces the word
// and the rejection threshold together in 32 steps; the back end takes no new
// item until it is finished. rejected words give no item.
// reset clears the queue, the output valid, the accumulator (0xDEADBEEF)
// and the draw counter; registers go to enable 0, low 0, high all ones.
// a stalled output holds its item; the back end waits, the queue fills and
// in_stall rises once both entries are taken.
module entropy_mixer_range_reducer (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  emr_pkg::in_item_t                in_item,
  output logic                             out_valid,
  input  logic                             out_stall,
  output emr_pkg::out_item_t               out_item,
  input  logic                             cfg_we,
  input  logic [emr_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [emr_pkg::WORD_W-1:0]       cfg_data
);
  import emr_pkg::*;

  cfg_t     cfg_r, cfg_nxt;
  logic     q_push;
  logic     q_full;
  logic     q_pop;
  logic     q_valid;
  q_entry_t q_entry;
  q_entry_t q_head;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_RANGE_ENABLE: cfg_nxt.range_enable = cfg_data[0];
        CFG_RANGE_LOW:    cfg_nxt.range_low    = cfg_data;
        CFG_RANGE_HIGH:   cfg_nxt.range_high   = cfg_data;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.range_enable <= 1'b0;
      cfg_r.range_low    <= '0;
      cfg_r.range_high   <= HIGH_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  emr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (q_entry)
  );

  emr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  emr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

`ifndef SYNTHESIS
  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_accept_fills_queue: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> q_valid)
    else $error("accepted item missing from queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");
`endif

endmodule

>>> hw/rtl/emr_front.sv
// front end: accepts items, mixes samples, steps the accumulator and classifies
module emr_front (
  input  logic              clk,
  input  logic              rst_n,
  input  emr_pkg::cfg_t     cfg,
  input  logic              in_valid,
  output logic              in_stall,
  input  emr_pkg::in_item_t in_item,
  input  logic              q_full,
  output logic              q_push,
  output emr_pkg::q_entry_t q_entry
);
  import emr_pkg::*;

  logic [WORD_W-1:0] acc_r, acc_nxt;
  logic [WORD_W-1:0] cnt_r, cnt_nxt;
  logic [WORD_W-1:0] mixed;
  logic [WORD_W-1:0] acc_mix;
  logic [WORD_W-1:0] acc_step;
  logic [WORD_W-1:0] cnt_inc;
  logic              empty_range;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    mixed = in_item.sample_a ^ rotl(in_item.sample_b, 7) ^ rotl(in_item.sample_c, 13)
          ^ rotl(in_item.sample_d, 17);
    acc_mix  = acc_r ^ mixed ^ in_item.timer_word;
    acc_step = acc_mix * LCG_MUL + LCG_ADD;
    cnt_inc  = cnt_r + 32'd1;
    empty_range = cfg.range_enable && (cfg.range_low >= cfg.range_high);

    acc_nxt = acc_r;
    cnt_nxt = cnt_r;
    if (empty_range) begin
      q_entry.kind  = KIND_EMPTY;
      q_entry.word  = cfg.range_low;
      q_entry.count = cnt_r;
    end else begin
      q_entry.kind  = cfg.range_enable ? KIND_RANGE : KIND_RAW;
      q_entry.word  = mixed ^ acc_step;
      q_entry.count = cnt_inc;
      if (q_push) begin
        acc_nxt = acc_step;
        cnt_nxt = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= ACC_RESET;
      cnt_r <= '0;
    end else begin
      acc_r <= acc_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

>>> hw/rtl/emr_queue.sv
// short item queue between front end and back end
module emr_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  emr_pkg::q_entry_t push_entry,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output emr_pkg::q_entry_t head
);
  import emr_pkg::*;

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  q_entry_t         mem_r [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full       = (count_r == CNT_W'(Q_DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

>>> hw/rtl/emr_back.sv
// back end: bit-serial range reduction, rejection and output register
module emr_back (
  input  logic               clk,
  input  logic               rst_n,
  input  emr_pkg::cfg_t      cfg,
  input  logic               q_valid,
  input  emr_pkg::q_entry_t  q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output emr_pkg::out_item_t out_item
);
  import emr_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_DONE
  } state_t;

  state_t            state_r, state_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_item_r, out_item_nxt;
  logic [WORD_W:0]   span_r, span_nxt;
  logic [WORD_W-1:0] word_r, word_nxt;
  logic [WORD_W-1:0] word_sh_r, word_sh_nxt;
  logic [WORD_W-1:0] thr_sh_r, thr_sh_nxt;
  logic [WORD_W:0]   rem_w_r, rem_w_nxt;
  logic [WORD_W:0]   rem_t_r, rem_t_nxt;
  logic [WORD_W-1:0] count_r, count_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_free;

  function automatic logic [WORD_W:0] rem_step(input logic [WORD_W:0] rem,
                                               input logic bit_in,
                                               input logic [WORD_W:0] span);
    logic [WORD_W+1:0] trial;
    logic [WORD_W+1:0] diff;
    trial = {rem, bit_in};
    diff  = trial - {1'b0, span};
    return (trial >= {1'b0, span}) ? diff[WORD_W:0] : trial[WORD_W:0];
  endfunction

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    span_nxt      = span_r;
    word_nxt      = word_r;
    word_sh_nxt   = word_sh_r;
    thr_sh_nxt    = thr_sh_r;
    rem_w_nxt     = rem_w_r;
    rem_t_nxt     = rem_t_r;
    count_nxt     = count_r;
    step_nxt      = step_r;
    q_pop         = 1'b0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          if (q_head.kind == KIND_RANGE) begin
            q_pop       = 1'b1;
            span_nxt    = {1'b0, cfg.range_high} - {1'b0, cfg.range_low} + 33'd1;
            word_nxt    = q_head.word;
            word_sh_nxt = q_head.word;
            thr_sh_nxt  = cfg.range_low - cfg.range_high - 32'd1;
            rem_w_nxt   = '0;
            rem_t_nxt   = '0;
            count_nxt   = q_head.count;
            step_nxt    = '0;
            state_nxt   = S_DIV;
          end else if (out_free) begin
            q_pop                     = 1'b1;
            out_valid_nxt             = 1'b1;
            out_item_nxt.random_value = q_head.word;
            out_item_nxt.draw_count   = q_head.count;
          end
        end
      end
      S_DIV: begin
        rem_w_nxt   = rem_step(rem_w_r, word_sh_r[WORD_W-1], span_r);
        rem_t_nxt   = rem_step(rem_t_r, thr_sh_r[WORD_W-1], span_r);
        word_sh_nxt = word_sh_r << 1;
        thr_sh_nxt  = thr_sh_r << 1;
        step_nxt    = step_r + STEP_W'(1);
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if ({1'b0, word_r} < rem_t_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          out_valid_nxt             = 1'b1;
          out_item_nxt.random_value = cfg.range_low + rem_w_r[WORD_W-1:0];
          out_item_nxt.draw_count   = count_r;
          state_nxt                 = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      step_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      step_r      <= step_nxt;
    end
    out_item_r <= out_item_nxt;
    span_r     <= span_nxt;
    word_r     <= word_nxt;
    word_sh_r  <= word_sh_nxt;
    thr_sh_r   <= thr_sh_nxt;
    rem_w_r    <= rem_w_nxt;
    rem_t_r    <= rem_t_nxt;
    count_r    <= count_nxt;
  end

endmodule
